FILE: design/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int ID_W            = 8;
    localparam int TIME_W          = 8;
    localparam int ENTRY_W         = ID_W + TIME_W;
    localparam int COUNT_W         = 8;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } spq_op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } spq_status_t;

endpackage

`default_nettype wire

FILE: design/spq_ram.sv
`default_nettype none

module spq_ram
    import spq_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(QUEUE_DEPTH_DEF)
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [ENTRY_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/spq_qptr.sv
`default_nettype none

module spq_qptr
    import spq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int PTR_W = $clog2(QUEUE_DEPTH_DEF),
    parameter int CNT_W = $clog2(QUEUE_DEPTH_DEF + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic              pop,
    output logic      [PTR_W-1:0]  head,
    output logic      [PTR_W-1:0]  tail,
    output logic      [CNT_W-1:0]  fill_next,
    output spq_status_t            status
);

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (push) begin
            tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end else if (pop) begin
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    assign head         = head_reg;
    assign tail         = tail_reg;
    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == FULL_CNT);

endmodule

`default_nettype wire

FILE: design/strict_priority_two_queue.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    operation, customer_id, is_business, duration
// m_       out        m_valid/m_ready    served_*, push_dropped, business_count, economy_count
//
// One transaction per cycle sustained while m_ready is high; a result is offered
// once it has passed the stage register (queue memory read and stage load at the
// accept edge), then the output register. Each queue has one write and one read port,
// and a transaction touches at most one of them.
// Reset clears pointers, counts and valids; queue memory is not cleared.
// m_ready low holds the output; s_ready drops once the in-flight stage is also held.
`default_nettype none

module strict_priority_two_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [ID_W-1:0]    s_customer_id,
    input  wire logic               s_is_business,
    input  wire logic [TIME_W-1:0]  s_duration,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_served_valid,
    output logic      [ID_W-1:0]    m_served_id,
    output logic                    m_served_business,
    output logic      [TIME_W-1:0]  m_served_time,
    output logic                    m_push_dropped,
    output logic      [COUNT_W-1:0] m_business_count,
    output logic      [COUNT_W-1:0] m_economy_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = CNT_W + COUNT_W;

    logic accept, is_push, drop;
    logic bus_push, eco_push, bus_pop, eco_pop;

    logic [PTR_W-1:0]   bus_head, bus_tail, eco_head, eco_tail;
    logic [CNT_W-1:0]   bus_fill_next, eco_fill_next;
    spq_status_t        bus_stat, eco_stat;
    logic [ENTRY_W-1:0] wr_word, bus_rd, eco_rd, sel_rd;
    logic [EXT_W-1:0]   bus_cnt_ext, eco_cnt_ext;

    logic               p1_valid_reg, p1_served_reg, p1_business_reg, p1_drop_reg;
    logic [COUNT_W-1:0] p1_bus_cnt_reg, p1_eco_cnt_reg;
    logic               p1_advance;

    logic               out_valid_reg, out_served_reg, out_business_reg, out_drop_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [TIME_W-1:0]  out_time_reg;
    logic [COUNT_W-1:0] out_bus_cnt_reg, out_eco_cnt_reg;

    assign p1_advance = p1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !p1_valid_reg || p1_advance;
    assign accept     = s_valid && s_ready;
    assign is_push    = (s_operation == OP_PUSH);

    assign bus_push = accept && is_push && s_is_business && !bus_stat.full;
    assign eco_push = accept && is_push && !s_is_business && !eco_stat.full;
    assign bus_pop  = accept && !is_push && !bus_stat.empty;
    assign eco_pop  = accept && !is_push && bus_stat.empty && !eco_stat.empty;
    assign drop     = is_push && (s_is_business ? bus_stat.full : eco_stat.full);

    assign wr_word  = {s_customer_id, s_duration};

    spq_qptr #(.DEPTH(QUEUE_DEPTH), .PTR_W(PTR_W), .CNT_W(CNT_W)) u_bus_ptr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (bus_push),
        .pop       (bus_pop),
        .head      (bus_head),
        .tail      (bus_tail),
        .fill_next (bus_fill_next),
        .status    (bus_stat)
    );

    spq_qptr #(.DEPTH(QUEUE_DEPTH), .PTR_W(PTR_W), .CNT_W(CNT_W)) u_eco_ptr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (eco_push),
        .pop       (eco_pop),
        .head      (eco_head),
        .tail      (eco_tail),
        .fill_next (eco_fill_next),
        .status    (eco_stat)
    );

    // A push lands at an edge before any later pop can read it, so no bypass.
    spq_ram #(.DEPTH(QUEUE_DEPTH), .ADDR_W(PTR_W)) u_bus_ram (
        .aclk    (aclk),
        .wr_en   (bus_push),
        .wr_addr (bus_tail),
        .wr_data (wr_word),
        .rd_en   (bus_pop),
        .rd_addr (bus_head),
        .rd_data (bus_rd)
    );

    spq_ram #(.DEPTH(QUEUE_DEPTH), .ADDR_W(PTR_W)) u_eco_ram (
        .aclk    (aclk),
        .wr_en   (eco_push),
        .wr_addr (eco_tail),
        .wr_data (wr_word),
        .rd_en   (eco_pop),
        .rd_addr (eco_head),
        .rd_data (eco_rd)
    );

    assign bus_cnt_ext = EXT_W'(bus_fill_next);
    assign eco_cnt_ext = EXT_W'(eco_fill_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_served_reg   <= bus_pop || eco_pop;
            p1_business_reg <= bus_pop;
            p1_drop_reg     <= drop;
            p1_bus_cnt_reg  <= bus_cnt_ext[COUNT_W-1:0];
            p1_eco_cnt_reg  <= eco_cnt_ext[COUNT_W-1:0];
        end
    end

    // read data holds while the stage is held: no new read until it moves on
    assign sel_rd = p1_business_reg ? bus_rd : eco_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance) begin
            out_served_reg   <= p1_served_reg;
            out_business_reg <= p1_business_reg;
            out_drop_reg     <= p1_drop_reg;
            out_id_reg       <= p1_served_reg ? sel_rd[ENTRY_W-1:TIME_W] : '0;
            out_time_reg     <= p1_served_reg ? sel_rd[TIME_W-1:0] : '0;
            out_bus_cnt_reg  <= p1_bus_cnt_reg;
            out_eco_cnt_reg  <= p1_eco_cnt_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_served_valid    = out_served_reg;
    assign m_served_id       = out_id_reg;
    assign m_served_business = out_business_reg;
    assign m_served_time     = out_time_reg;
    assign m_push_dropped    = out_drop_reg;
    assign m_business_count  = out_bus_cnt_reg;
    assign m_economy_count   = out_eco_cnt_reg;

    a_pop_prefers_business: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_push && !bus_stat.empty |=> p1_served_reg && p1_business_reg)
        else $error("pop skipped non-empty business queue");

    a_one_queue_per_txn: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({bus_push, eco_push, bus_pop, eco_pop}) <= 1)
        else $error("transaction touches more than one queue port");

    a_served_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_served_valid |-> !m_push_dropped && (m_served_business || 1'b1))
        else $error("served result also flagged as dropped");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !p1_advance |=> p1_valid_reg && $stable(p1_served_reg))
        else $error("in-flight transaction lost while output stalled");

endmodule

`default_nettype wire
